// ===== hdl/wav_stream_parser_core_assert.svh =====
// Assertion macros used by the checker file wsp_checker.sv.
`ifndef WAV_STREAM_PARSER_CORE_ASSERT_SVH
`define WAV_STREAM_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define WSP_ASSERT_IMP(lbl, a_clk, a_rst_n, ante, cons) \
  lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
    else $error("wsp port check failed");

// next-cycle implication
`define WSP_ASSERT_NXT(lbl, a_clk, a_rst_n, ante, cons) \
  lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
    else $error("wsp port check failed");

`endif

// ===== hdl/wsp_pkg.sv =====
package wsp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [5:0]  MIN_FILE_BYTES = 6'd44;
  localparam logic [5:0]  RIFF_TAG_END   = 6'd3;
  localparam logic [5:0]  WAVE_TAG_END   = 6'd11;
  localparam logic [31:0] FMT_MIN_LEN    = 32'd16;
  localparam logic [3:0]  FMT_LAST_BYTE  = 4'd15;

  localparam logic [15:0] FMT_CODE_PCM   = 16'd1;
  localparam logic [15:0] FMT_CODE_FLOAT = 16'd3;
  localparam logic [15:0] BITS_PCM       = 16'd16;
  localparam logic [15:0] BITS_FLOAT     = 16'd32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_MISSING    = 3'd2,
    ST_NOT_MONO   = 3'd3,
    ST_BAD_FORMAT = 3'd4,
    ST_ORDER      = 3'd5
  } wsp_status_t;

  typedef struct packed {
    logic        is_summary;
    logic [31:0] sample_bits;
    wsp_status_t status;
    logic [31:0] sample_rate;
    logic        last_of_run;
  } wsp_result_t;

  // results produced by one accepted byte, first goes out first
  typedef struct packed {
    logic [1:0]  count;
    wsp_result_t first;
    wsp_result_t second;
  } wsp_push_t;

endpackage

// ===== hdl/wsp_parser.sv =====
module wsp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                end_of_file,
  output wsp_pkg::wsp_push_t  push
);

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_CHUNK_HDR = 3'd1,
    PH_FMT       = 3'd2,
    PH_DATA      = 3'd3,
    PH_SKIP      = 3'd4,
    PH_DEAD      = 3'd5
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [5:0]          fbc_r, fbc_nxt;
  logic [31:0]         tag_r, tag_nxt;
  logic [31:0]         len_r, len_nxt;
  logic [32:0]         off_r, off_nxt;
  logic [15:0]         fmt_r, fmt_nxt;
  logic [15:0]         ch_r, ch_nxt;
  logic [31:0]         rate_r, rate_nxt;
  logic [15:0]         width_r, width_nxt;
  logic [23:0]         asm_r, asm_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                fmt_seen_r, fmt_seen_nxt;
  logic                data_seen_r, data_seen_nxt;
  logic                emit_r, emit_nxt;
  wsp_pkg::wsp_status_t err_r, err_nxt;

  logic [32:0] body;
  assign body = {1'b0, len_r} + {32'b0, len_r[0]};

  function automatic logic [31:0] pcm16_to_f32(input logic [15:0] raw);
    logic [15:0] mag;
    logic [15:0] norm;
    logic [3:0]  p;
    mag = raw[15] ? (~raw + 16'd1) : raw;
    p = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (mag[k]) p = 4'(k);
    end
    norm = mag << (4'd15 - p);
    if (raw == 16'd0) return 32'd0;
    return {raw[15], {4'b0, p} + 8'd112, norm[14:0], 8'b0};
  endfunction

  function automatic logic fmt_supported(input logic [15:0] code, input logic [15:0] bits);
    return (code == wsp_pkg::FMT_CODE_PCM && bits == wsp_pkg::BITS_PCM) ||
           (code == wsp_pkg::FMT_CODE_FLOAT && bits == wsp_pkg::BITS_FLOAT);
  endfunction

  always_comb begin
    logic [32:0]          off_inc;
    logic [31:0]          tag_new;
    logic [31:0]          len_new;
    logic [3:0]           o;
    logic                 pcm16;
    logic                 done;
    logic [31:0]          word;
    wsp_pkg::wsp_result_t sample;
    wsp_pkg::wsp_result_t summary;
    wsp_pkg::wsp_status_t st;

    phase_nxt     = phase_r;
    fbc_nxt       = fbc_r;
    tag_nxt       = tag_r;
    len_nxt       = len_r;
    off_nxt       = off_r;
    fmt_nxt       = fmt_r;
    ch_nxt        = ch_r;
    rate_nxt      = rate_r;
    width_nxt     = width_r;
    asm_nxt       = asm_r;
    idx_nxt       = idx_r;
    fmt_seen_nxt  = fmt_seen_r;
    data_seen_nxt = data_seen_r;
    emit_nxt      = emit_r;
    err_nxt       = err_r;
    push          = '0;

    off_inc = off_r + 33'd1;
    tag_new = {tag_r[23:0], in_byte};
    len_new = len_r;
    o       = off_r[3:0];
    pcm16   = (fmt_r == wsp_pkg::FMT_CODE_PCM) && (width_r == wsp_pkg::BITS_PCM);
    word    = {8'b0, asm_r} | ({24'b0, in_byte} << {idx_r, 3'b000});
    done    = pcm16 ? (idx_r != 2'd0) : (idx_r == 2'd3);
    sample  = '0;
    sample.sample_bits = pcm16 ? pcm16_to_f32(word[15:0]) : word;
    sample.last_of_run = !end_of_file;
    summary = '0;
    st      = wsp_pkg::ST_OK;

    if (accept) begin
      if (fbc_r < wsp_pkg::MIN_FILE_BYTES) fbc_nxt = fbc_r + 6'd1;

      case (phase_r)
        PH_HEADER: begin
          tag_nxt = tag_new;
          if ((fbc_r == wsp_pkg::RIFF_TAG_END && tag_new != wsp_pkg::TAG_RIFF) ||
              (fbc_r == wsp_pkg::WAVE_TAG_END && tag_new != wsp_pkg::TAG_WAVE)) begin
            err_nxt   = wsp_pkg::ST_BAD_HEADER;
            phase_nxt = PH_DEAD;
          end else if (fbc_r == wsp_pkg::WAVE_TAG_END) begin
            phase_nxt = PH_CHUNK_HDR;
            off_nxt   = '0;
          end
        end
        PH_CHUNK_HDR: begin
          if (off_r < 33'd4) begin
            tag_nxt = tag_new;
            if (off_r == 33'd0) len_new = '0;
          end else begin
            tag_new = tag_r;
            len_new = len_r | ({24'b0, in_byte} << {off_r[1:0], 3'b000});
          end
          len_nxt = len_new;
          off_nxt = off_inc;
          if (off_r == 33'd7) begin
            // header complete: open the chunk body
            off_nxt = '0;
            asm_nxt = '0;
            idx_nxt = '0;
            if (tag_new == wsp_pkg::TAG_FMT) begin
              phase_nxt = PH_FMT;
            end else if (tag_new == wsp_pkg::TAG_DATA) begin
              phase_nxt = PH_DATA;
              if (data_seen_r) begin
                err_nxt = wsp_pkg::ST_ORDER;
              end else if (fmt_seen_r && rate_r != 32'd0 && ch_r == 16'd1 &&
                           fmt_supported(fmt_r, width_r)) begin
                emit_nxt = 1'b1;
              end
              data_seen_nxt = 1'b1;
            end else begin
              phase_nxt = PH_SKIP;
            end
            if (len_new == 32'd0) begin
              emit_nxt  = 1'b0;
              phase_nxt = PH_CHUNK_HDR;
            end
          end
        end
        PH_FMT: begin
          if (len_r >= wsp_pkg::FMT_MIN_LEN && off_r < 33'd16) begin
            if (!data_seen_r) begin
              if (o < 4'd2)       fmt_nxt[{o[0], 3'b000} +: 8] = in_byte;
              else if (o < 4'd4)  ch_nxt[{o[0], 3'b000} +: 8] = in_byte;
              else if (o < 4'd8)  rate_nxt[{o[1:0], 3'b000} +: 8] = in_byte;
              else if (o >= 4'd14) width_nxt[{o[0], 3'b000} +: 8] = in_byte;
              if (o == wsp_pkg::FMT_LAST_BYTE) fmt_seen_nxt = 1'b1;
            end else if (o == wsp_pkg::FMT_LAST_BYTE) begin
              err_nxt = wsp_pkg::ST_ORDER;
            end
          end
          off_nxt = off_inc;
          if (off_inc >= body) begin
            phase_nxt = PH_CHUNK_HDR;
            off_nxt   = '0;
          end
        end
        PH_DATA: begin
          if (emit_r && off_r < {1'b0, len_r}) begin
            if (done) begin
              push.count = 2'd1;
              push.first = sample;
              asm_nxt    = '0;
              idx_nxt    = '0;
            end else begin
              asm_nxt = word[23:0];
              idx_nxt = idx_r + 2'd1;
            end
          end
          off_nxt = off_inc;
          if (off_inc >= body) begin
            phase_nxt = PH_CHUNK_HDR;
            off_nxt   = '0;
            emit_nxt  = 1'b0;
          end
        end
        PH_SKIP: begin
          off_nxt = off_inc;
          if (off_inc >= body) begin
            phase_nxt = PH_CHUNK_HDR;
            off_nxt   = '0;
          end
        end
        default: phase_nxt = PH_DEAD;
      endcase

      if (end_of_file) begin
        if (err_nxt == wsp_pkg::ST_BAD_HEADER || fbc_nxt < wsp_pkg::MIN_FILE_BYTES ||
            phase_nxt == PH_HEADER)
          st = wsp_pkg::ST_BAD_HEADER;
        else if (err_nxt == wsp_pkg::ST_ORDER)
          st = wsp_pkg::ST_ORDER;
        else if (!data_seen_nxt || !fmt_seen_nxt || rate_nxt == 32'd0)
          st = wsp_pkg::ST_MISSING;
        else if (ch_nxt != 16'd1)
          st = wsp_pkg::ST_NOT_MONO;
        else if (!fmt_supported(fmt_nxt, width_nxt))
          st = wsp_pkg::ST_BAD_FORMAT;
        else
          st = wsp_pkg::ST_OK;
        summary.is_summary  = 1'b1;
        summary.status      = st;
        summary.sample_rate = (st == wsp_pkg::ST_OK) ? rate_nxt : 32'd0;
        summary.last_of_run = 1'b1;
        if (push.count == 2'd1) begin
          push.count  = 2'd2;
          push.second = summary;
        end else begin
          push.count = 2'd1;
          push.first = summary;
        end
        // file done: back to reset state for the next one
        phase_nxt     = PH_HEADER;
        fbc_nxt       = '0;
        tag_nxt       = '0;
        len_nxt       = '0;
        off_nxt       = '0;
        fmt_nxt       = '0;
        ch_nxt        = '0;
        rate_nxt      = '0;
        width_nxt     = '0;
        asm_nxt       = '0;
        idx_nxt       = '0;
        fmt_seen_nxt  = 1'b0;
        data_seen_nxt = 1'b0;
        emit_nxt      = 1'b0;
        err_nxt       = wsp_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      fbc_r       <= '0;
      tag_r       <= '0;
      len_r       <= '0;
      off_r       <= '0;
      fmt_r       <= '0;
      ch_r        <= '0;
      rate_r      <= '0;
      width_r     <= '0;
      asm_r       <= '0;
      idx_r       <= '0;
      fmt_seen_r  <= 1'b0;
      data_seen_r <= 1'b0;
      emit_r      <= 1'b0;
      err_r       <= wsp_pkg::ST_OK;
    end else begin
      phase_r     <= phase_nxt;
      fbc_r       <= fbc_nxt;
      tag_r       <= tag_nxt;
      len_r       <= len_nxt;
      off_r       <= off_nxt;
      fmt_r       <= fmt_nxt;
      ch_r        <= ch_nxt;
      rate_r      <= rate_nxt;
      width_r     <= width_nxt;
      asm_r       <= asm_nxt;
      idx_r       <= idx_nxt;
      fmt_seen_r  <= fmt_seen_nxt;
      data_seen_r <= data_seen_nxt;
      emit_r      <= emit_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

// ===== hdl/wsp_out_queue.sv =====
module wsp_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wsp_pkg::wsp_push_t   push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wsp_pkg::wsp_result_t out_word
);

  wsp_pkg::wsp_result_t            entry_r [wsp_pkg::QUEUE_DEPTH];
  logic [wsp_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [wsp_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [wsp_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            pop;

  // room for the worst case of two words from one byte
  assign room      = cnt_r <= wsp_pkg::QCNT_W'(wsp_pkg::QUEUE_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_word  = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + wsp_pkg::QPTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + wsp_pkg::QPTR_W'(pop);
    cnt_nxt    = cnt_r + wsp_pkg::QCNT_W'(push.count) - wsp_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entry_r[wr_ptr_r] <= push.first;
    if (push.count == 2'd2) entry_r[wr_ptr_r + wsp_pkg::QPTR_W'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/wav_stream_parser_core.sv =====
// Channel | Dir | tdata (low bit up)                              | tuser      | tlast
// in_     | in  | in_byte[7:0]                                    | -          | end_of_file
// out_    | out | sample_bits[31:0], status[34:32], rate[66:35], 0 | is_summary | last_of_run
//
// One file byte per cycle while in_tready is high; the parser state updates on the accepting edge and
// the results are written into a 4-word output queue at that same edge, so they
// show on out_ once any words ahead of them in the queue have left.
// The final byte of a file can give two words (sample then summary).
// in_tready drops while more than two words wait in the queue.
// rst_n is synchronous: parser back to the RIFF header phase, queue empty.
module wav_stream_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // file bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte[7:0]
  input  logic        in_tlast,   // end_of_file
  // decoded samples and end-of-file summary
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // sample_bits[31:0], status[34:32],
                                  // sample_rate[66:35], zero fill [71:67]
  output logic        out_tuser,  // is_summary
  output logic        out_tlast   // last_of_run
);

  logic                 accept;
  wsp_pkg::wsp_push_t   push;
  wsp_pkg::wsp_result_t head;

  // a byte moves only when the queue can take both possible words
  assign accept = in_tvalid && in_tready;

  wsp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_byte     (in_tdata),
    .end_of_file (in_tlast),
    .push        (push)
  );

  wsp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (head)
  );

  assign out_tdata = {5'b0, head.sample_rate, head.status, head.sample_bits};
  assign out_tuser = head.is_summary;
  assign out_tlast = head.last_of_run;

endmodule

// ===== hdl/wsp_checker.sv =====
`include "wav_stream_parser_core_assert.svh"

module wsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // stalled word stays put
  `WSP_ASSERT_NXT(a_out_hold_valid, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `WSP_ASSERT_NXT(a_out_hold_data, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // a summary always closes the run of its byte
  `WSP_ASSERT_IMP(a_summary_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)

  // sample words carry no status and no rate
  `WSP_ASSERT_IMP(a_sample_clean, clk, rst_n, out_tvalid && !out_tuser, out_tdata[71:32] == 40'd0)

endmodule

bind wav_stream_parser_core wsp_checker u_wsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
